// File: rtl/tpchit_pkg.sv
// Shared constants and register codes for the TPC hit position reconstruction block.
// No dependencies; imported by the top level and its port checker.
package tpchit_pkg;

    localparam int TIME_BITS_DEF = 12;
    localparam int NUM_DRIFT     = 4;
    localparam int NUM_PAIR      = 2;

    localparam int REG_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam int POS_W   = 20;
    localparam int SUM_W   = 14;
    localparam int GATES_W = 3;

    // result beat: pos_x, pos_y, pos_valid, x_difference, gates_passed,
    // any_fired, sum_a..sum_d, zero fill
    localparam int OUT_USED = 3 * POS_W + 1 + GATES_W + 1 + NUM_DRIFT * SUM_W;
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

    localparam int OFS_X     = 0;
    localparam int OFS_Y     = OFS_X + POS_W;
    localparam int OFS_VALID = OFS_Y + POS_W;
    localparam int OFS_XD    = OFS_VALID + 1;
    localparam int OFS_GATES = OFS_XD + POS_W;
    localparam int OFS_FIRED = OFS_GATES + GATES_W;
    localparam int OFS_SUM   = OFS_FIRED + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GATE_LOWS     = 3'd0,
        REG_GATE_HIGHS    = 3'd1,
        REG_DRIFT_SLOPES  = 3'd2,
        REG_DRIFT_OFFSETS = 3'd3,
        REG_PAIR_SLOPES   = 3'd4,
        REG_PAIR_OFFSETS  = 3'd5
    } cfg_reg_t;

    localparam logic [REG_W-1:0] GATE_HIGHS_RST = 64'h1FFF_1FFF_1FFF_1FFF;

    // floor(u/3) = (u * DIV3_K) >> DIV3_SHIFT, exact for u below 2**DIV3_W
    localparam int               DIV3_W     = 25;
    localparam int               DIV3_SHIFT = 26;
    localparam logic [DIV3_W-1:0] DIV3_K    = 25'd22369622;
    localparam int               YCL_W      = 23;

endpackage

// File: rtl/tpc_hit_position_reconstruct.sv
// TPC hit position reconstruction: checksums, gates, calibrated means, six-stage pipeline.
// Depends on tpchit_pkg.
// Each accepted beat passes stage registers 1 to 6 to become a result beat on the m_ side.
// Throughput: one event per cycle while m_tready is high; every stage has its own
// valid bit and only the stages behind a stalled result hold, so bubbles are squeezed
// out under back-pressure. The only multi-step work is the divide by three for a y mean
// over three channels, done as a reciprocal multiply in stage 5.
// Reset (aresetn low, synchronous): all stage valid bits clear, the configuration
// registers return to their reset values (upper gates 8191, all else zero).
module tpc_hit_position_reconstruct #(
    parameter int TIME_BITS = tpchit_pkg::TIME_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [tpchit_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [tpchit_pkg::REG_W-1:0]      cfg_wr_data,
    // event input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // drift_a, drift_b, drift_c, drift_d, left_first, right_first,
    // left_second, right_second (TIME_BITS each, from bit 0 up)
    input  logic [8*TIME_BITS-1:0]            s_tdata,
    // result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pos_x(20), pos_y(20), pos_valid(1), x_difference(20), gates_passed(3),
    // any_fired(1), sum_a..sum_d(14 each), zero fill (from bit 0 up)
    output logic [tpchit_pkg::OUT_W-1:0]      m_tdata
);
    import tpchit_pkg::*;

    localparam int TW   = TIME_BITS;
    localparam int CSW  = TW + 2;                  // checksum L+R-2d
    localparam int CMPW = (CSW > 16) ? CSW : 16;   // gate compare width
    localparam int DFW  = TW + 1;                  // L-R
    localparam int YPW  = 17 + TW;                 // drift slope product
    localparam int YTW  = YPW + 1;                 // plus offset
    localparam int YSW  = YTW + 2;                 // sum of four
    localparam int YAW  = YSW + 1;                 // with rounding term
    localparam int XPW  = 32 + DFW;                // pair slope product
    localparam int XTW  = XPW + 1;
    localparam int XSW  = XTW + 1;
    localparam int XAW  = XSW + 1;
    localparam int PRW  = 2 * DIV3_W;

    localparam logic signed [CMPW-1:0] CS_MAX = CMPW'(8191);
    localparam logic signed [CMPW-1:0] CS_MIN = CMPW'(-8192);
    localparam logic signed [YAW-1:0]  YCL_MAX = YAW'((1 <<< (YCL_W - 1)) - 1);
    localparam logic signed [YAW-1:0]  YCL_MIN = YAW'(-(1 <<< (YCL_W - 1)));

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [REG_W-1:0] gate_lows_reg, gate_highs_reg, drift_slopes_reg;
    logic [REG_W-1:0] drift_offsets_reg, pair_slopes_reg, pair_offsets_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_lows_reg     <= '0;
            gate_highs_reg    <= GATE_HIGHS_RST;
            drift_slopes_reg  <= '0;
            drift_offsets_reg <= '0;
            pair_slopes_reg   <= '0;
            pair_offsets_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_wr_index))
                REG_GATE_LOWS:     gate_lows_reg     <= cfg_wr_data;
                REG_GATE_HIGHS:    gate_highs_reg    <= cfg_wr_data;
                REG_DRIFT_SLOPES:  drift_slopes_reg  <= cfg_wr_data;
                REG_DRIFT_OFFSETS: drift_offsets_reg <= cfg_wr_data;
                REG_PAIR_SLOPES:   pair_slopes_reg   <= cfg_wr_data;
                REG_PAIR_OFFSETS:  pair_offsets_reg  <= cfg_wr_data;
                default: ;  // indexes beyond the list are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its successor loads
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6     = !v6_reg || m_tready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: unpack the beat, form checksums and L-R
    // ---------------------------------------------------------------
    logic [TW-1:0]          drift_in [NUM_DRIFT];
    logic [TW-1:0]          left_in  [NUM_PAIR];
    logic [TW-1:0]          right_in [NUM_PAIR];
    logic signed [CSW-1:0]  cs_next  [NUM_DRIFT];
    logic signed [DFW-1:0]  diff_next[NUM_PAIR];
    logic [NUM_PAIR-1:0]    pnz_next;
    logic                   fired_next;

    always_comb begin
        for (int p = 0; p < NUM_PAIR; p++) begin
            left_in[p]   = s_tdata[(4 + 2 * p) * TW +: TW];
            right_in[p]  = s_tdata[(5 + 2 * p) * TW +: TW];
            diff_next[p] = $signed({1'b0, left_in[p]}) - $signed({1'b0, right_in[p]});
            pnz_next[p]  = (|left_in[p]) || (|right_in[p]);
        end
        fired_next = |pnz_next;
        for (int i = 0; i < NUM_DRIFT; i++) begin
            drift_in[i] = s_tdata[i * TW +: TW];
            cs_next[i]  = $signed({2'b00, left_in[i / 2]}) + $signed({2'b00, right_in[i / 2]})
                        - $signed({1'b0, drift_in[i], 1'b0});
            fired_next  = fired_next || (|drift_in[i]);
        end
    end

    logic [TW-1:0]          drift1_reg[NUM_DRIFT];
    logic signed [CSW-1:0]  cs1_reg   [NUM_DRIFT];
    logic signed [DFW-1:0]  diff1_reg [NUM_PAIR];
    logic [NUM_PAIR-1:0]    pnz1_reg;
    logic                   fired1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            drift1_reg <= drift_in;
            cs1_reg    <= cs_next;
            diff1_reg  <= diff_next;
            pnz1_reg   <= pnz_next;
            fired1_reg <= fired_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: gate test, calibration products, checksum saturation
    // ---------------------------------------------------------------
    logic signed [CMPW-1:0]  csx     [NUM_DRIFT];
    logic signed [CMPW-1:0]  glo     [NUM_DRIFT];
    logic signed [CMPW-1:0]  ghi     [NUM_DRIFT];
    logic [NUM_DRIFT-1:0]    pass_next, ok_next, yen_next;
    logic signed [YPW-1:0]   yprod_next[NUM_DRIFT];
    logic signed [XPW-1:0]   xprod_next[NUM_PAIR];
    logic signed [SUM_W-1:0] sum14_next[NUM_DRIFT];

    always_comb begin
        for (int i = 0; i < NUM_DRIFT; i++) begin
            csx[i]  = CMPW'(cs1_reg[i]);
            glo[i]  = CMPW'($signed(gate_lows_reg[16 * i +: 16]));
            ghi[i]  = CMPW'($signed(gate_highs_reg[16 * i +: 16]));
            pass_next[i] = (csx[i] >= glo[i]) && (csx[i] <= ghi[i]);
            // a channel on an empty pair passes if its checksum is inside the gates but is not OK
            ok_next[i]   = pass_next[i] && pnz1_reg[i / 2];
            yen_next[i]  = ok_next[i] && (|drift1_reg[i]);
            yprod_next[i] = $signed(drift_slopes_reg[16 * i +: 16])
                          * $signed({1'b0, drift1_reg[i]});
            if (csx[i] > CS_MAX)
                sum14_next[i] = SUM_W'(CS_MAX);
            else if (csx[i] < CS_MIN)
                sum14_next[i] = SUM_W'(CS_MIN);
            else
                sum14_next[i] = csx[i][SUM_W-1:0];
        end
        for (int p = 0; p < NUM_PAIR; p++) begin
            xprod_next[p] = $signed(pair_slopes_reg[32 * p +: 32]) * diff1_reg[p];
        end
    end

    logic signed [YPW-1:0]   yprod2_reg[NUM_DRIFT];
    logic signed [XPW-1:0]   xprod2_reg[NUM_PAIR];
    logic [NUM_DRIFT-1:0]    pass2_reg, ok2_reg, yen2_reg;
    logic signed [SUM_W-1:0] sum2_reg  [NUM_DRIFT];
    logic                    fired2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            yprod2_reg <= yprod_next;
            xprod2_reg <= xprod_next;
            pass2_reg  <= pass_next;
            ok2_reg    <= ok_next;
            yen2_reg   <= yen_next;
            sum2_reg   <= sum14_next;
            fired2_reg <= fired1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: add offsets, accumulate masked terms, count
    // ---------------------------------------------------------------
    logic signed [YTW-1:0] yterm[NUM_DRIFT];
    logic signed [XTW-1:0] xv   [NUM_PAIR];
    logic [NUM_PAIR-1:0]   xen;
    logic signed [YSW-1:0] ysum_next;
    logic signed [XSW-1:0] xsum_next, xdiff_next;
    logic [2:0]            cnt_next;
    logic [1:0]            cx_next;
    logic [GATES_W-1:0]    passed_next;
    logic                  valid_next;

    always_comb begin
        ysum_next = '0;
        for (int i = 0; i < NUM_DRIFT; i++) begin
            yterm[i] = YTW'(yprod2_reg[i])
                     + (YTW'($signed(drift_offsets_reg[16 * i +: 16])) <<< 6);
            if (yen2_reg[i])
                ysum_next = ysum_next + YSW'(yterm[i]);
        end
        for (int p = 0; p < NUM_PAIR; p++) begin
            xen[p] = ok2_reg[2 * p] || ok2_reg[2 * p + 1];
            xv[p]  = xen[p] ? XTW'(xprod2_reg[p])
                              + (XTW'($signed(pair_offsets_reg[32 * p +: 32])) <<< 8)
                            : '0;
        end
        xsum_next   = XSW'(xv[0]) + XSW'(xv[1]);
        xdiff_next  = XSW'(xv[0]) - XSW'(xv[1]);
        cnt_next    = 3'($countones(yen2_reg));
        cx_next     = 2'($countones(xen));
        passed_next = GATES_W'($countones(pass2_reg));
        valid_next  = fired2_reg && (cnt_next != '0) && (cx_next != '0);
    end

    logic signed [YSW-1:0]   ysum3_reg;
    logic signed [XSW-1:0]   xsum3_reg, xdiff3_reg;
    logic [2:0]              cnt3_reg;
    logic [1:0]              cx3_reg;
    logic [GATES_W-1:0]      passed3_reg;
    logic                    valid3_reg, fired3_reg;
    logic signed [SUM_W-1:0] sum3_reg[NUM_DRIFT];

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            ysum3_reg   <= ysum_next;
            xsum3_reg   <= xsum_next;
            xdiff3_reg  <= xdiff_next;
            cnt3_reg    <= cnt_next;
            cx3_reg     <= cx_next;
            passed3_reg <= passed_next;
            valid3_reg  <= valid_next;
            fired3_reg  <= fired2_reg;
            sum3_reg    <= sum2_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: round to nearest (halves up), shift out power-of-two counts,
    // prepare the divide by three
    // ---------------------------------------------------------------
    function automatic logic signed [POS_W-1:0] sat_ya(input logic signed [YAW-1:0] v);
        if (v > YAW'((1 <<< (POS_W - 1)) - 1))
            return POS_W'((1 <<< (POS_W - 1)) - 1);
        else if (v < YAW'(-(1 <<< (POS_W - 1))))
            return POS_W'(-(1 <<< (POS_W - 1)));
        else
            return v[POS_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_xa(input logic signed [XAW-1:0] v);
        if (v > XAW'((1 <<< (POS_W - 1)) - 1))
            return POS_W'((1 <<< (POS_W - 1)) - 1);
        else if (v < XAW'(-(1 <<< (POS_W - 1))))
            return POS_W'(-(1 <<< (POS_W - 1)));
        else
            return v[POS_W-1:0];
    endfunction

    logic signed [YAW-1:0]   yr, ya, ysh;
    logic signed [YCL_W-1:0] ycl;
    logic [DIV3_W-1:0]       u_next;
    logic signed [XAW-1:0]   xr, pr;
    logic signed [POS_W-1:0] ydir_next, px_next, pd_next;

    always_comb begin
        // floor((n + 32c) / 64) first; the count division follows
        yr = YAW'(ysum3_reg) + YAW'(signed'({1'b0, cnt3_reg, 5'b00000}));
        ya = yr >>> 6;
        case (cnt3_reg)
            3'd2:    ysh = ya >>> 1;
            3'd4:    ysh = ya >>> 2;
            default: ysh = ya;
        endcase
        ydir_next = sat_ya(ysh);
        // clamping keeps saturation intact and bounds the divider input
        if (ya > YCL_MAX)
            ycl = YCL_MAX[YCL_W-1:0];
        else if (ya < YCL_MIN)
            ycl = YCL_MIN[YCL_W-1:0];
        else
            ycl = ya[YCL_W-1:0];
        u_next = DIV3_W'(ycl) + DIV3_W'(3 <<< (YCL_W - 1));

        if (cx3_reg == 2'd2)
            xr = (XAW'(xsum3_reg) + XAW'(256)) >>> 9;
        else
            xr = (XAW'(xsum3_reg) + XAW'(128)) >>> 8;
        px_next = sat_xa(xr);
        pr      = (XAW'(xdiff3_reg) + XAW'(128)) >>> 8;
        pd_next = sat_xa(pr);
    end

    logic signed [POS_W-1:0] ydir4_reg, px4_reg, pd4_reg;
    logic [DIV3_W-1:0]       u4_reg;
    logic                    div3_4_reg, valid4_reg, fired4_reg;
    logic [GATES_W-1:0]      passed4_reg;
    logic signed [SUM_W-1:0] sum4_reg[NUM_DRIFT];

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            ydir4_reg   <= ydir_next;
            px4_reg     <= px_next;
            pd4_reg     <= pd_next;
            u4_reg      <= u_next;
            div3_4_reg  <= (cnt3_reg == 3'd3);
            valid4_reg  <= valid3_reg;
            fired4_reg  <= fired3_reg;
            passed4_reg <= passed3_reg;
            sum4_reg    <= sum3_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: reciprocal multiply for the divide by three
    // ---------------------------------------------------------------
    logic [PRW-1:0]          prod5_reg;
    logic signed [POS_W-1:0] ydir5_reg, px5_reg, pd5_reg;
    logic                    div3_5_reg, valid5_reg, fired5_reg;
    logic [GATES_W-1:0]      passed5_reg;
    logic signed [SUM_W-1:0] sum5_reg[NUM_DRIFT];

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            prod5_reg   <= PRW'(u4_reg) * PRW'(DIV3_K);
            ydir5_reg   <= ydir4_reg;
            px5_reg     <= px4_reg;
            pd5_reg     <= pd4_reg;
            div3_5_reg  <= div3_4_reg;
            valid5_reg  <= valid4_reg;
            fired5_reg  <= fired4_reg;
            passed5_reg <= passed4_reg;
            sum5_reg    <= sum4_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: finish y, blank invalid fields, pack the result beat
    // ---------------------------------------------------------------
    logic signed [DIV3_W-1:0] q3;
    logic signed [POS_W-1:0]  py_fin;
    logic [OUT_W-1:0]         tdata_next, tdata_reg;

    always_comb begin
        // remove the bias added before the multiply
        q3 = $signed({1'b0, prod5_reg[PRW-1:DIV3_SHIFT]}) - DIV3_W'(1 <<< (YCL_W - 1));
        if (q3 > DIV3_W'((1 <<< (POS_W - 1)) - 1))
            py_fin = POS_W'((1 <<< (POS_W - 1)) - 1);
        else if (q3 < DIV3_W'(-(1 <<< (POS_W - 1))))
            py_fin = POS_W'(-(1 <<< (POS_W - 1)));
        else
            py_fin = q3[POS_W-1:0];
        if (!div3_5_reg)
            py_fin = ydir5_reg;

        tdata_next = '0;
        if (valid5_reg) begin
            tdata_next[OFS_X +: POS_W]  = px5_reg;
            tdata_next[OFS_Y +: POS_W]  = py_fin;
            tdata_next[OFS_VALID]       = 1'b1;
            tdata_next[OFS_XD +: POS_W] = pd5_reg;
        end
        if (fired5_reg) begin
            tdata_next[OFS_GATES +: GATES_W] = passed5_reg;
            tdata_next[OFS_FIRED]            = 1'b1;
            for (int i = 0; i < NUM_DRIFT; i++)
                tdata_next[OFS_SUM + i * SUM_W +: SUM_W] = sum5_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy6)
            tdata_reg <= tdata_next;
    end

    assign m_tdata = tdata_reg;

endmodule

// File: rtl/tpchit_chk.sv
// Port-level checker for tpc_hit_position_reconstruct, attached by bind.
// Depends on tpchit_pkg.
module tpchit_chk (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [tpchit_pkg::OUT_W-1:0] m_tdata
);
    import tpchit_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // nothing fired: every field zero
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[OFS_FIRED] |-> m_tdata == '0)
        else $error("fields set on an empty event");

    // no valid position: positions blanked
    a_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[OFS_VALID] |->
            m_tdata[OFS_X +: POS_W] == '0 && m_tdata[OFS_Y +: POS_W] == '0
            && m_tdata[OFS_XD +: POS_W] == '0)
        else $error("position set without pos_valid");

    // gate count bounded, fill bits zero
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OFS_GATES +: GATES_W] <= GATES_W'(NUM_DRIFT)
            && m_tdata[OUT_W-1:OUT_USED] == '0)
        else $error("gate count or fill out of range");

    // output empty after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tpc_hit_position_reconstruct tpchit_chk u_tpchit_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
